// ===== src/ostb_pkg.sv =====
// ----------------------------------------------------------------------------
// ostb_pkg
// Shared types and constants for the one-shot timer bank.
// ----------------------------------------------------------------------------
package ostb_pkg;

  localparam int NUM_TIMERS_DEF = 8;
  localparam int COUNT_BITS_DEF = 16;
  localparam int ID_W           = 3;
  localparam int TAG_W          = 16;
  localparam int TICK_W         = 16;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [ID_W-1:0]   timer_id;
    logic              deferred_mode;
    logic [TICK_W-1:0] tick_count;
    logic [TAG_W-1:0]  handler_tag;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0]  expired_id;
    logic             expired_deferred;
    logic [TAG_W-1:0] expired_tag;
    logic             last;
  } out_t;

  // per-cell control, shared by all cells except start and stop
  typedef struct packed {
    logic tick;
    logic rotate;
    logic start;
    logic stop;
  } cell_ctl_t;

  // what the head cell of the ring shows the sequencer
  typedef struct packed {
    logic             expired;
    logic             mode;
    logic [TAG_W-1:0] tag;
    logic             more;
  } head_t;

endpackage

// ===== src/ostb_cell.sv =====
// ----------------------------------------------------------------------------
// ostb_cell
// One timer of the bank: count, tag, mode, running and expired flags.
// Decrements on tick, loads on start, clears running on stop, shifts to its ring neighbor on rotate.
// ----------------------------------------------------------------------------
module ostb_cell
  import ostb_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cell_ctl_t             ctl,
  input  logic                  ld_mode,
  input  logic [TICK_W-1:0]     ld_count,
  input  logic [TAG_W-1:0]      ld_tag,
  input  logic                  nb_run,
  input  logic                  nb_exp,
  input  logic                  nb_mode,
  input  logic [TAG_W-1:0]      nb_tag,
  input  logic [COUNT_BITS-1:0] nb_rem,
  output logic                  run,
  output logic                  exp_flag,
  output logic                  mode,
  output logic [TAG_W-1:0]      tag,
  output logic [COUNT_BITS-1:0] rem
);

  logic                  run_r, run_nxt;
  logic                  exp_r, exp_nxt;
  logic                  mode_r, mode_nxt;
  logic [TAG_W-1:0]      tag_r, tag_nxt;
  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic [COUNT_BITS-1:0] dec;

  assign dec = rem_r - COUNT_BITS'(1);

  always_comb begin
    run_nxt  = run_r;
    exp_nxt  = exp_r;
    mode_nxt = mode_r;
    tag_nxt  = tag_r;
    rem_nxt  = rem_r;
    if (ctl.rotate) begin
      run_nxt  = nb_run;
      exp_nxt  = nb_exp;
      mode_nxt = nb_mode;
      tag_nxt  = nb_tag;
      rem_nxt  = nb_rem;
    end else if (ctl.start) begin
      run_nxt  = 1'b1;
      mode_nxt = ld_mode;
      tag_nxt  = ld_tag;
      rem_nxt  = COUNT_BITS'(ld_count);
    end else if (ctl.stop) begin
      run_nxt = 1'b0;
    end else if (ctl.tick) begin
      exp_nxt = 1'b0;
      if (run_r) begin
        rem_nxt = dec;
        // reaching zero stops the timer and flags it for the report scan
        if (dec == '0) begin
          run_nxt = 1'b0;
          exp_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      exp_r  <= 1'b0;
      mode_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      exp_r  <= exp_nxt;
      mode_r <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
    rem_r <= rem_nxt;
  end

  assign run      = run_r;
  assign exp_flag = exp_r;
  assign mode     = mode_r;
  assign tag      = tag_r;
  assign rem      = rem_r;

endmodule

// ===== src/ostb_ctrl.sv =====
// ----------------------------------------------------------------------------
// ostb_ctrl
// Sequencer: walks the ring once per tick and registers one expiry report
// per expired timer in the output stage.
// ----------------------------------------------------------------------------
module ostb_ctrl
  import ostb_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  tick_cmd,
  output logic  in_ready,
  input  head_t head,
  output logic  rotate,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             ov_r, ov_nxt;
  out_t             od_r, od_nxt;
  logic             step;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    step      = 1'b0;
    in_ready  = 1'b0;
    if (out_ready) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && tick_cmd) begin
          state_nxt = ST_SCAN;
          idx_nxt   = '0;
        end
      end
      ST_SCAN: begin
        // advance the ring only when the output stage can take a beat
        step = !ov_r || out_ready;
        if (step) begin
          if (head.expired) begin
            ov_nxt                  = 1'b1;
            od_nxt.expired_id       = ID_W'(idx_r);
            od_nxt.expired_deferred = head.mode;
            od_nxt.expired_tag      = head.tag;
            od_nxt.last             = !head.more;
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_IDLE;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt;
  end

  assign rotate    = step;
  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

// ===== src/one_shot_timer_bank.sv =====
// ----------------------------------------------------------------------------
// one_shot_timer_bank
// Bank of one-shot countdown timers built as a ring of timer cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  channel (valid/ready) carries commands: tick, start or stop.
//   Start loads count, handler tag and mode into one cell and marks it
//   running; stop clears the running mark. Both report nothing.
//   Start or stop with an index beyond the bank is dropped.
//   A tick decrements every running cell at once, then the ring rotates
//   NUM_TIMERS steps past the head cell; each expired timer seen at the
//   head becomes one out_* beat, in ascending index order, with last set
//   on the final report of that tick. A tick holds in_ready low for the
//   whole scan, which stalls in any step in which out_ready is low while
//   a report waits.
//   The output register holds its beat while out_ready is low; the next
//   command is taken once the scan ends, even if the last report still waits.
//   Reset (rst_n low, synchronous) stops all timers and empties the output
//   stage; counts and tags are only meaningful after a start.
// ----------------------------------------------------------------------------
module one_shot_timer_bank
  import ostb_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic                  run_v  [NUM_TIMERS];
  logic                  exp_v  [NUM_TIMERS];
  logic                  mode_v [NUM_TIMERS];
  logic [TAG_W-1:0]      tag_v  [NUM_TIMERS];
  logic [COUNT_BITS-1:0] rem_v  [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] run_bits, exp_bits;

  logic  in_beat, tick_cmd, rotate;
  head_t head;

  assign in_beat  = in_valid && in_ready;
  assign tick_cmd = (in_data.command == CMD_TICK);

  genvar k;
  generate
    for (k = 0; k < NUM_TIMERS; k++) begin : g_cell
      localparam int NB = (k + 1) % NUM_TIMERS;
      cell_ctl_t ctl;
      logic      nb_exp;
      logic      sel;

      assign sel = (int'(in_data.timer_id) == k);
      assign ctl.tick   = in_beat && tick_cmd;
      assign ctl.rotate = rotate;
      assign ctl.start  = in_beat && sel && (in_data.command == CMD_START);
      assign ctl.stop   = in_beat && sel && (in_data.command == CMD_STOP);
      // the head's flag is consumed as it wraps to the tail
      if (k == NUM_TIMERS - 1) begin : g_tail
        assign nb_exp = 1'b0;
      end else begin : g_body
        assign nb_exp = exp_v[NB];
      end

      ostb_cell #(
        .COUNT_BITS (COUNT_BITS)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .ld_mode  (in_data.deferred_mode),
        .ld_count (in_data.tick_count),
        .ld_tag   (in_data.handler_tag),
        .nb_run   (run_v[NB]),
        .nb_exp   (nb_exp),
        .nb_mode  (mode_v[NB]),
        .nb_tag   (tag_v[NB]),
        .nb_rem   (rem_v[NB]),
        .run      (run_v[k]),
        .exp_flag (exp_v[k]),
        .mode     (mode_v[k]),
        .tag      (tag_v[k]),
        .rem      (rem_v[k])
      );

      assign run_bits[k] = run_v[k];
      assign exp_bits[k] = exp_v[k];
    end
  endgenerate

  assign head.expired = exp_v[0];
  assign head.mode    = mode_v[0];
  assign head.tag     = tag_v[0];
  // any flag left behind the head means more reports follow
  assign head.more    = |(exp_bits >> 1);

  ostb_ctrl #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .tick_cmd  (tick_cmd),
    .in_ready  (in_ready),
    .head      (head),
    .rotate    (rotate),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_tick_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && tick_cmd |=> !in_ready)
    else $error("tick beat did not start the report scan");

  a_run_exp_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (run_bits & exp_bits) == '0)
    else $error("timer both running and flagged expired");

  a_idle_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> exp_bits == '0)
    else $error("expiry flag left over after scan");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("bank not idle after reset");

endmodule
